[rtl/dasc_pkg.sv]
// Shared types and constants for the deadlock avoidance safety checker.
// Used by the controller, the datapath, the top level and the testbench.
package dasc_pkg;

    localparam int MAX_PROCESSES_DEF = 16;
    localparam int MAX_RESOURCES_DEF = 16;
    localparam int COUNT_WIDTH_DEF   = 8;

    // configuration port
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROCESSES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_RESOURCES = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_RESET_COUNT   = 5'd16;

    // item command codes
    localparam logic [2:0] CMD_WRITE_ALLOC = 3'd0;
    localparam logic [2:0] CMD_WRITE_CLAIM = 3'd1;
    localparam logic [2:0] CMD_WRITE_AVAIL = 3'd2;
    localparam logic [2:0] CMD_CHECK       = 3'd3;
    localparam logic [2:0] CMD_REQUEST     = 3'd4;

    // result status codes
    localparam logic [1:0] ST_SAFE       = 2'd0;
    localparam logic [1:0] ST_UNSAFE     = 2'd1;
    localparam logic [1:0] ST_OVER_NEED  = 2'd2;
    localparam logic [1:0] ST_OVER_AVAIL = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_INIT,
        OP_TEST,
        OP_ADD,
        OP_JUDGE,
        OP_GRANT
    } dp_op_t;

    typedef enum logic [1:0] {
        SEL_SEQ,
        SEL_UNSAFE,
        SEL_NEED,
        SEL_AVAIL
    } out_sel_t;

    typedef struct packed {
        dp_op_t   op;
        logic     clr_j;
        logic     check_start;
        logic     sweep_start;
        logic     next_proc;
        logic     proc_done;
        logic     emit_start;
        logic     emit_next;
        logic     load_out;
        out_sel_t out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic       j_done;
        logic       clr_done;
        logic       fail;
        logic       flag_need;
        logic       flag_avail;
        logic       i_at_end;
        logic       cur_finished;
        logic       progress;
        logic       count_full;
        logic       k_last;
        logic [2:0] in_command;
        logic       in_last;
        logic       in_row_ok;
    } dp_stat_t;

endpackage

[rtl/dasc_item_if.sv]
// Input channel of the safety checker: valid/ready plus one command item.
// Depends on nothing.
interface dasc_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [3:0] process_index;
    logic [3:0] resource_index;
    logic [7:0] amount;
    logic       request_last;

    modport source (
        output valid, command, process_index, resource_index, amount, request_last,
        input  ready
    );
    modport sink (
        input  valid, command, process_index, resource_index, amount, request_last,
        output ready
    );
endinterface

[rtl/dasc_result_if.sv]
// Output channel of the safety checker: valid/ready plus one result item.
// Depends on nothing.
interface dasc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] sequence_process;
    logic       result_last;

    modport source (
        output valid, status, sequence_process, result_last,
        input  ready
    );
    modport sink (
        input  valid, status, sequence_process, result_last,
        output ready
    );
endinterface

[rtl/deadlock_avoidance_safety_check_top.sv]
// Top level of the banker's-algorithm safety checker.
// Depends on dasc_pkg, dasc_item_if, dasc_result_if, dasc_ctrl, dasc_dpath.
//
// After reset the block runs a clearing pass over every address of the allocation and
// claim stores and over the available store, and takes no item meanwhile; configuration
// writes are taken at any time the block is idle. Table writes (allocation, claim,
// available) and non-final request elements are accepted back to back. A safety check
// walks the tables through one RAM read port per table, one resource per cycle: it first
// copies available into work, then visits each process; an unfinished process gets a need
// test and, if it fits, a work update; sweeps repeat until one finishes no process. A
// final request element adds a judgement and, if granted, a table update before its check.
// Each safe result takes one read of the stored safe order. The input stays closed during
// a run; the last result may still wait in the output register while new items are accepted.
module deadlock_avoidance_safety_check_top import dasc_pkg::*; #(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = MAX_RESOURCES_DEF,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    dasc_item_if.sink            items,
    dasc_result_if.source        results
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_fire;

    assign in_fire = items.valid && items.ready;

    // sequencer: owns the handshakes and the run order
    dasc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // tables, counters and the result register
    dasc_dpath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_fire          (in_fire),
        .command          (items.command),
        .process_index    (items.process_index),
        .resource_index   (items.resource_index),
        .amount           (items.amount),
        .request_last     (items.request_last),
        .cmd              (cmd),
        .stat             (stat),
        .status           (results.status),
        .sequence_process (results.sequence_process),
        .result_last      (results.result_last)
    );

    // any non-safe outcome is a single item
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.status != ST_SAFE) |-> results.result_last)
        else $error("error result without result_last");

    // a check closes the input for at least the next cycle
    a_check_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (items.command == CMD_CHECK) |=> !items.ready)
        else $error("input open right after a check item");

    // the final request element starts a judgement or a rejection
    a_last_req_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (items.command == CMD_REQUEST) && items.request_last |=> !items.ready)
        else $error("input open right after a final request element");

endmodule

[rtl/dasc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module dasc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/dasc_ctrl.sv]
// Sequencer of the safety checker: clear pass, table loads, safety sweeps,
// request judgement and result emission. Depends on dasc_pkg.
module dasc_ctrl import dasc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_PROC,
        S_TEST,
        S_ADD,
        S_RESULT,
        S_EMIT_RD,
        S_EMIT_LD,
        S_OUT,
        S_JUDGE,
        S_GRANT
    } state_t;

    state_t   state_reg, state_next;
    logic     out_valid_reg, out_valid_next;
    out_sel_t sel_reg, sel_next;
    logic     in_fire;
    logic     out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign in_fire   = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = OP_NONE;
        cmd.out_sel    = SEL_SEQ;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (stat.in_command == CMD_CHECK)
                    begin
                        cmd.check_start = 1'b1;
                        state_next      = S_INIT;
                    end
                    else if (stat.in_command == CMD_REQUEST && stat.in_last)
                    begin
                        if (!stat.in_row_ok)
                        begin
                            sel_next   = SEL_NEED;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_JUDGE;
                        end
                    end
                end
            end
            S_INIT:
            begin
                cmd.op = OP_INIT;
                if (stat.j_done)
                begin
                    cmd.clr_j       = 1'b1;
                    cmd.sweep_start = 1'b1;
                    state_next      = S_PROC;
                end
            end
            S_PROC:
            begin
                if (stat.i_at_end)
                begin
                    if (stat.progress)
                    begin
                        cmd.sweep_start = 1'b1;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
                else if (stat.cur_finished)
                begin
                    cmd.next_proc = 1'b1;
                end
                else
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                cmd.op = OP_TEST;
                if (stat.j_done)
                begin
                    cmd.clr_j = 1'b1;
                    if (stat.fail)
                    begin
                        cmd.next_proc = 1'b1;
                        state_next    = S_PROC;
                    end
                    else
                    begin
                        state_next = S_ADD;
                    end
                end
            end
            S_ADD:
            begin
                cmd.op = OP_ADD;
                if (stat.j_done)
                begin
                    cmd.clr_j     = 1'b1;
                    cmd.proc_done = 1'b1;
                    state_next    = S_PROC;
                end
            end
            S_RESULT:
            begin
                if (stat.count_full)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_EMIT_RD;
                end
                else
                begin
                    sel_next   = SEL_UNSAFE;
                    state_next = S_OUT;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_sel    = SEL_SEQ;
                    cmd.emit_next  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = stat.k_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_sel    = sel_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_JUDGE:
            begin
                cmd.op = OP_JUDGE;
                if (stat.j_done)
                begin
                    cmd.clr_j = 1'b1;
                    if (stat.flag_need)
                    begin
                        sel_next   = SEL_NEED;
                        state_next = S_OUT;
                    end
                    else if (stat.flag_avail)
                    begin
                        sel_next   = SEL_AVAIL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_GRANT;
                    end
                end
            end
            S_GRANT:
            begin
                cmd.op = OP_GRANT;
                if (stat.j_done)
                begin
                    cmd.clr_j       = 1'b1;
                    cmd.check_start = 1'b1;
                    state_next      = S_INIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            sel_reg       <= SEL_SEQ;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

endmodule

[rtl/dasc_dpath.sv]
// Datapath of the safety checker: tables in RAM, element pipeline, sweep
// counters, finished marks and the result register. Depends on dasc_pkg, dasc_ram.
module dasc_dpath import dasc_pkg::*; #(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = MAX_RESOURCES_DEF,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_fire,
    input  logic [2:0]           command,
    input  logic [3:0]           process_index,
    input  logic [3:0]           resource_index,
    input  logic [7:0]           amount,
    input  logic                 request_last,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic [1:0]           status,
    output logic [3:0]           sequence_process,
    output logic                 result_last
);

    localparam int P   = MAX_PROCESSES;
    localparam int R   = MAX_RESOURCES;
    localparam int W   = COUNT_WIDTH;
    localparam int PW  = $clog2(P);
    localparam int RW  = (R > 1) ? $clog2(R) : 1;
    localparam int CW  = $clog2(P + 1);
    localparam int RCW = $clog2(R + 1);
    localparam int TD  = P * (2 ** RW);
    localparam int TAW = PW + RW;
    localparam int WKW = W + $clog2(P + 1);

    logic [CFG_W-1:0] np_cfg_reg, nr_cfg_reg;
    logic [CW-1:0]    np;
    logic [RCW-1:0]   nr;

    logic [RCW-1:0] j_reg, j_next;
    logic           d_valid_reg;
    logic [RW-1:0]  d_j_reg;
    logic [TAW-1:0] clr_reg;
    logic [CW-1:0]  i_reg, count_reg, k_reg;
    logic           progress_reg, fail_reg, need_reg, avail_reg;
    logic [P-1:0]   finished_reg;
    logic [PW-1:0]  req_row_reg;
    logic [1:0]     status_reg;
    logic [3:0]     seq_reg;
    logic           last_reg;

    logic [31:0]    in_p_wide, in_r_wide, amt_wide;
    logic [PW-1:0]  in_p;
    logic [RW-1:0]  in_r;
    logic [W-1:0]   amt;
    logic           row_ok, col_ok;

    logic           active, issue, first;
    logic [RW-1:0]  j_idx;
    logic [PW-1:0]  row;

    logic [W-1:0]   alloc_q, claim_q, avail_q, req_q, need_q;
    logic [WKW-1:0] work_q;
    logic [PW-1:0]  order_q;
    logic [PW+3:0]  order_ext;

    logic           alloc_we, claim_we, avail_we, work_we, req_we;
    logic [TAW-1:0] alloc_waddr, claim_waddr;
    logic [W-1:0]   alloc_wdata, claim_wdata, avail_wdata;
    logic [RW-1:0]  avail_waddr;
    logic [WKW-1:0] work_wdata;

    logic           test_fail, judge_need, judge_avail;
    logic           fail_base, need_base, avail_base;
    logic           k_last;

    // effective in-use counts: zero acts as one, oversize acts as the table size
    always_comb
    begin
        if (np_cfg_reg == '0)
            np = CW'(1);
        else if (int'(np_cfg_reg) > P)
            np = CW'(P);
        else
            np = CW'(np_cfg_reg);
        if (nr_cfg_reg == '0)
            nr = RCW'(1);
        else if (int'(nr_cfg_reg) > R)
            nr = RCW'(R);
        else
            nr = RCW'(nr_cfg_reg);
    end

    assign in_p_wide = 32'(process_index);
    assign in_r_wide = 32'(resource_index);
    assign amt_wide  = 32'(amount);
    assign in_p      = in_p_wide[PW-1:0];
    assign in_r      = in_r_wide[RW-1:0];
    assign amt       = amt_wide[W-1:0];
    assign row_ok    = int'(process_index) < P;
    assign col_ok    = int'(resource_index) < R;

    assign active = (cmd.op == OP_INIT) || (cmd.op == OP_TEST) || (cmd.op == OP_ADD)
                 || (cmd.op == OP_JUDGE) || (cmd.op == OP_GRANT);
    assign issue  = active && (j_reg < nr);
    assign first  = active && (j_reg == '0);
    assign j_idx  = j_reg[RW-1:0];
    assign row    = ((cmd.op == OP_JUDGE) || (cmd.op == OP_GRANT)) ? req_row_reg
                                                                  : i_reg[PW-1:0];

    assign need_q = (claim_q > alloc_q) ? (claim_q - alloc_q) : '0;

    assign test_fail   = d_valid_reg && (cmd.op == OP_TEST)
                      && ({{(WKW-W){1'b0}}, need_q} > work_q);
    assign judge_need  = d_valid_reg && (cmd.op == OP_JUDGE) && (req_q > need_q);
    assign judge_avail = d_valid_reg && (cmd.op == OP_JUDGE) && (req_q > avail_q);

    // flags restart on the first element of each pass
    assign fail_base  = first ? 1'b0 : fail_reg;
    assign need_base  = first ? 1'b0 : need_reg;
    assign avail_base = first ? 1'b0 : avail_reg;

    assign k_last = (CW'(k_reg + 1'b1) == count_reg);

    always_comb
    begin
        j_next = j_reg;
        if (cmd.clr_j)
            j_next = '0;
        else if (issue)
            j_next = RCW'(j_reg + 1'b1);
    end

    // write ports
    always_comb
    begin
        alloc_we    = 1'b0;
        alloc_waddr = {in_p, in_r};
        alloc_wdata = amt;
        claim_we    = 1'b0;
        claim_waddr = {in_p, in_r};
        claim_wdata = amt;
        avail_we    = 1'b0;
        avail_waddr = in_r;
        avail_wdata = amt;
        if (cmd.op == OP_CLEAR)
        begin
            alloc_we    = 1'b1;
            alloc_waddr = clr_reg;
            alloc_wdata = '0;
            claim_we    = 1'b1;
            claim_waddr = clr_reg;
            claim_wdata = '0;
            avail_we    = int'(clr_reg) < R;
            avail_waddr = clr_reg[RW-1:0];
            avail_wdata = '0;
        end
        else if (d_valid_reg && (cmd.op == OP_GRANT))
        begin
            alloc_we    = 1'b1;
            alloc_waddr = {req_row_reg, d_j_reg};
            alloc_wdata = alloc_q + req_q;
            avail_we    = 1'b1;
            avail_waddr = d_j_reg;
            avail_wdata = avail_q - req_q;
        end
        else if (in_fire)
        begin
            alloc_we = (command == CMD_WRITE_ALLOC) && row_ok && col_ok;
            claim_we = (command == CMD_WRITE_CLAIM) && row_ok && col_ok;
            avail_we = (command == CMD_WRITE_AVAIL) && col_ok;
        end
    end

    assign work_we    = d_valid_reg && ((cmd.op == OP_INIT) || (cmd.op == OP_ADD));
    assign work_wdata = (cmd.op == OP_INIT) ? {{(WKW-W){1'b0}}, avail_q}
                                            : work_q + {{(WKW-W){1'b0}}, alloc_q};
    assign req_we     = in_fire && (command == CMD_REQUEST) && col_ok;

    dasc_ram #(.WIDTH(W), .DEPTH(TD)) u_alloc (
        .clk   (clk),
        .we    (alloc_we),
        .waddr (alloc_waddr),
        .wdata (alloc_wdata),
        .raddr ({row, j_idx}),
        .rdata (alloc_q)
    );

    dasc_ram #(.WIDTH(W), .DEPTH(TD)) u_claim (
        .clk   (clk),
        .we    (claim_we),
        .waddr (claim_waddr),
        .wdata (claim_wdata),
        .raddr ({row, j_idx}),
        .rdata (claim_q)
    );

    dasc_ram #(.WIDTH(W), .DEPTH(R)) u_avail (
        .clk   (clk),
        .we    (avail_we),
        .waddr (avail_waddr),
        .wdata (avail_wdata),
        .raddr (j_idx),
        .rdata (avail_q)
    );

    dasc_ram #(.WIDTH(WKW), .DEPTH(R)) u_work (
        .clk   (clk),
        .we    (work_we),
        .waddr (d_j_reg),
        .wdata (work_wdata),
        .raddr (j_idx),
        .rdata (work_q)
    );

    dasc_ram #(.WIDTH(W), .DEPTH(R)) u_reqbuf (
        .clk   (clk),
        .we    (req_we),
        .waddr (in_r),
        .wdata (amt),
        .raddr (j_idx),
        .rdata (req_q)
    );

    dasc_ram #(.WIDTH(PW), .DEPTH(P)) u_order (
        .clk   (clk),
        .we    (cmd.proc_done),
        .waddr (count_reg[PW-1:0]),
        .wdata (i_reg[PW-1:0]),
        .raddr (k_reg[PW-1:0]),
        .rdata (order_q)
    );

    assign order_ext = {4'b0000, order_q};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            np_cfg_reg   <= CFG_RESET_COUNT;
            nr_cfg_reg   <= CFG_RESET_COUNT;
            j_reg        <= '0;
            d_valid_reg  <= 1'b0;
            clr_reg      <= '0;
            i_reg        <= '0;
            count_reg    <= '0;
            k_reg        <= '0;
            progress_reg <= 1'b0;
            fail_reg     <= 1'b0;
            need_reg     <= 1'b0;
            avail_reg    <= 1'b0;
            finished_reg <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_NUM_PROCESSES))
                np_cfg_reg <= cfg_data;
            if (cfg_we && (cfg_index == CFG_NUM_RESOURCES))
                nr_cfg_reg <= cfg_data;
            j_reg       <= j_next;
            d_valid_reg <= issue;
            if (cmd.op == OP_CLEAR)
                clr_reg <= TAW'(clr_reg + 1'b1);
            fail_reg  <= fail_base | test_fail;
            need_reg  <= need_base | judge_need;
            avail_reg <= avail_base | judge_avail;
            if (cmd.sweep_start)
                i_reg <= '0;
            else if (cmd.next_proc || cmd.proc_done)
                i_reg <= CW'(i_reg + 1'b1);
            if (cmd.sweep_start)
                progress_reg <= 1'b0;
            else if (cmd.proc_done)
                progress_reg <= 1'b1;
            if (cmd.check_start)
            begin
                count_reg    <= '0;
                finished_reg <= '0;
            end
            else if (cmd.proc_done)
            begin
                count_reg                   <= CW'(count_reg + 1'b1);
                finished_reg[i_reg[PW-1:0]] <= 1'b1;
            end
            if (cmd.emit_start)
                k_reg <= '0;
            else if (cmd.emit_next)
                k_reg <= CW'(k_reg + 1'b1);
        end
    end

    // payload registers: delayed element index, request row and result item
    always_ff @(posedge clk)
    begin
        d_j_reg <= j_idx;
        if (in_fire && (command == CMD_REQUEST) && request_last)
            req_row_reg <= in_p;
        if (cmd.load_out)
        begin
            case (cmd.out_sel)
                SEL_SEQ:    status_reg <= ST_SAFE;
                SEL_UNSAFE: status_reg <= ST_UNSAFE;
                SEL_NEED:   status_reg <= ST_OVER_NEED;
                default:    status_reg <= ST_OVER_AVAIL;
            endcase
            seq_reg  <= (cmd.out_sel == SEL_SEQ) ? order_ext[3:0] : 4'd0;
            last_reg <= (cmd.out_sel == SEL_SEQ) ? k_last : 1'b1;
        end
    end

    assign status           = status_reg;
    assign sequence_process  = seq_reg;
    assign result_last       = last_reg;

    always_comb
    begin
        stat              = '0;
        stat.j_done       = active && (j_reg == nr);
        stat.clr_done     = (cmd.op == OP_CLEAR) && (clr_reg == TAW'(TD - 1));
        stat.fail         = fail_base | test_fail;
        stat.flag_need    = need_base | judge_need;
        stat.flag_avail   = avail_base | judge_avail;
        stat.i_at_end     = (i_reg == np);
        stat.cur_finished = finished_reg[i_reg[PW-1:0]];
        stat.progress     = progress_reg;
        stat.count_full   = (count_reg == np);
        stat.k_last       = k_last;
        stat.in_command   = command;
        stat.in_last      = request_last;
        stat.in_row_ok    = row_ok;
    end

endmodule

[test/deadlock_avoidance_safety_check_top_tb.sv]
// Testbench for the banker's-algorithm safety checker: directed and random item streams
// checked against a scoreboard with its own model of the tables.
// Depends on dasc_pkg, dasc_item_if, dasc_result_if and deadlock_avoidance_safety_check_top.
module deadlock_avoidance_safety_check_top_tb;
    import dasc_pkg::*;

    localparam int NPROC     = MAX_PROCESSES_DEF;
    localparam int NRES      = MAX_RESOURCES_DEF;
    localparam int MAX_GAP   = 18;
    localparam int LIMIT     = 10000000;
    localparam int RAND_ITEMS = 200;

    // one expected result item
    typedef struct {
        logic [1:0] status;
        logic [3:0] seq_proc;
        logic       last;
    } outcome_t;

    // Scoreboard: keeps its own copy of the tables and the registers,
    // predicts results for each accepted item and checks them in order.
    class banker_scoreboard;
        logic [7:0] alloc [NPROC][NRES];
        logic [7:0] claim [NPROC][NRES];
        logic [7:0] avail [NRES];
        logic [7:0] req_buf [NRES];
        logic [4:0] reg_np;
        logic [4:0] reg_nr;
        outcome_t   pending [$];
        int         errors;

        function void clear();
            foreach (alloc[i, j])
            begin
                alloc[i][j] = '0;
                claim[i][j] = '0;
            end
            foreach (avail[j])
            begin
                avail[j]   = '0;
                req_buf[j] = '0;
            end
            reg_np = CFG_RESET_COUNT;
            reg_nr = CFG_RESET_COUNT;
            errors = 0;
        endfunction

        function int eff_count(logic [4:0] v, int hi);
            if (v == 0)
                return 1;
            return (v > hi) ? hi : int'(v);
        endfunction

        function int need(int p, int r);
            return (claim[p][r] > alloc[p][r]) ? int'(claim[p][r]) - int'(alloc[p][r]) : 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_NUM_PROCESSES)
                reg_np = val;
            else
                reg_nr = val;
        endfunction

        function void push(logic [1:0] st, int seqp, logic last);
            outcome_t o;
            o.status   = st;
            o.seq_proc = seqp[3:0];
            o.last     = last;
            pending.push_back(o);
        endfunction

        // repeated sweeps until one finishes nobody
        function void safety_sweep();
            int  np;
            int  nr;
            int  work [NRES];
            bit  done [NPROC];
            int  order [$];
            bit  progress;
            bit  fits;
            np = eff_count(reg_np, NPROC);
            nr = eff_count(reg_nr, NRES);
            for (int j = 0; j < nr; j++)
                work[j] = avail[j];
            foreach (done[i])
                done[i] = 0;
            do
            begin
                progress = 0;
                for (int i = 0; i < np; i++)
                begin
                    if (!done[i])
                    begin
                        fits = 1;
                        for (int j = 0; j < nr; j++)
                            if (need(i, j) > work[j])
                                fits = 0;
                        if (fits)
                        begin
                            for (int j = 0; j < nr; j++)
                                work[j] += alloc[i][j];
                            done[i] = 1;
                            order.push_back(i);
                            progress = 1;
                        end
                    end
                end
            end
            while (progress);
            if (order.size() == np)
            begin
                foreach (order[k])
                    push(ST_SAFE, order[k], k == np - 1);
            end
            else
                push(ST_UNSAFE, 0, 1'b1);
        endfunction

        function void note_item(logic [2:0] cmd, logic [3:0] p, logic [3:0] r,
                                logic [7:0] amt, logic last);
            int nr;
            bit over_need;
            bit over_avail;
            case (cmd)
                CMD_WRITE_ALLOC: alloc[p][r] = amt;
                CMD_WRITE_CLAIM: claim[p][r] = amt;
                CMD_WRITE_AVAIL: avail[r] = amt;
                CMD_CHECK:       safety_sweep();
                CMD_REQUEST:
                begin
                    req_buf[r] = amt;
                    if (last)
                    begin
                        nr = eff_count(reg_nr, NRES);
                        over_need  = 0;
                        over_avail = 0;
                        for (int j = 0; j < nr; j++)
                        begin
                            if (req_buf[j] > need(p, j))
                                over_need = 1;
                            if (req_buf[j] > avail[j])
                                over_avail = 1;
                        end
                        if (over_need)
                            push(ST_OVER_NEED, 0, 1'b1);
                        else if (over_avail)
                            push(ST_OVER_AVAIL, 0, 1'b1);
                        else
                        begin
                            for (int j = 0; j < nr; j++)
                            begin
                                alloc[p][j] = alloc[p][j] + req_buf[j];
                                avail[j]    = avail[j] - req_buf[j];
                            end
                            safety_sweep();
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [1:0] st, logic [3:0] seqp, logic last);
            outcome_t o;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d seq=%0d last=%0d",
                         $time, st, seqp, last);
                errors++;
                return;
            end
            o = pending.pop_front();
            if (st !== o.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, o.status, st);
                errors++;
            end
            if (seqp !== o.seq_proc)
            begin
                $display("%0t: sequence_process expected %0d actual %0d",
                         $time, o.seq_proc, seqp);
                errors++;
            end
            if (last !== o.last)
            begin
                $display("%0t: result_last expected %0d actual %0d", $time, o.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    dasc_item_if   items ();
    dasc_result_if results ();

    deadlock_avoidance_safety_check_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items.sink),
        .results   (results.source)
    );

    banker_scoreboard sb;
    bit     no_idle;        // set for stretches with back-to-back traffic
    int     cycles;
    int     rand_sent;
    int     np_use;         // effective sizes of the current phase
    int     nr_use;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard stop on a hang
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result monitor: values read here are the ones before this edge's updates
    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
            sb.check_result(results.status, results.sequence_process, results.result_last);
    end

    // result sink: random stalls before each item, none during idle-free stretches
    initial
    begin
        int n;
        results.ready <= 1'b0;
        @(posedge clk);
        wait (rst_n);
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (n > 0)
            begin
                results.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            results.ready <= 1'b1;
            do
                @(posedge clk);
            while (!results.valid);
        end
    end

    function int pick_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // drive one item and wait for its handshake; valid stays high when no gap follows
    task send(logic [2:0] cmd, logic [3:0] p, logic [3:0] r, logic [7:0] amt, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            items.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items.valid          <= 1'b1;
        items.command        <= cmd;
        items.process_index  <= p;
        items.resource_index <= r;
        items.amount         <= amt;
        items.request_last   <= last;
        do
            @(posedge clk);
        while (!items.ready);
        sb.note_item(cmd, p, r, amt, last);
    endtask

    // full request vector over the resources in use, random column order
    task send_request(logic [3:0] p, int amt_hi);
        int cols [$];
        int k;
        for (int j = 0; j < nr_use; j++)
            cols.push_back(j);
        cols.shuffle();
        for (k = 0; k < cols.size(); k++)
            send(CMD_REQUEST, p, cols[k][3:0], 8'($urandom_range(0, amt_hi)),
                 k == cols.size() - 1);
    endtask

    task drain();
        items.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        // final result may sit in the output register, then a write or two in flight
        repeat (20) @(posedge clk);
    endtask

    task write_cfg(logic [CFG_W-1:0] np, logic [CFG_W-1:0] nr);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NUM_PROCESSES;
        cfg_data  <= np;
        @(posedge clk);
        cfg_index <= CFG_NUM_RESOURCES;
        cfg_data  <= nr;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(CFG_NUM_PROCESSES, np);
        sb.set_reg(CFG_NUM_RESOURCES, nr);
        np_use = sb.eff_count(np, NPROC);
        nr_use = sb.eff_count(nr, NRES);
    endtask

    // random traffic for one phase: mostly table loads, request vectors and checks
    task random_phase(int count);
        int pick;
        int hi;
        int stop_at;
        stop_at = rand_sent + count;
        while (rand_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                no_idle = ~no_idle;
            if (pick < 30)
            begin
                // load the in-use part of the tables with small counts, within the budget
                hi = $urandom_range(1, 8);
                for (int i = 0; i < np_use && rand_sent < stop_at; i++)
                    for (int j = 0; j < nr_use && rand_sent < stop_at; j++)
                    begin
                        send(CMD_WRITE_CLAIM, i[3:0], j[3:0], 8'($urandom_range(0, hi)), 1'b0);
                        send(CMD_WRITE_ALLOC, i[3:0], j[3:0], 8'($urandom_range(0, hi)), 1'b0);
                        rand_sent += 2;
                    end
                for (int j = 0; j < nr_use; j++)
                begin
                    send(CMD_WRITE_AVAIL, 4'd0, j[3:0], 8'($urandom_range(0, 2 * hi)), 1'b0);
                    rand_sent++;
                end
                send(CMD_CHECK, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
                rand_sent++;
            end
            else if (pick < 60)
            begin
                send_request(4'($urandom_range(0, np_use - 1)),
                             ($urandom_range(0, 4) == 0) ? 255 : 3);
                rand_sent += nr_use;
            end
            else if (pick < 80)
            begin
                // any write anywhere, full field ranges
                send(3'($urandom_range(0, 2)), 4'($urandom), 4'($urandom), 8'($urandom),
                     1'($urandom));
                rand_sent++;
            end
            else if (pick < 92)
            begin
                send(CMD_CHECK, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
                rand_sent++;
            end
            else if (pick < 96)
            begin
                // request element without the final mark; row left at any value
                send(CMD_REQUEST, 4'($urandom), 4'($urandom_range(0, nr_use - 1)),
                     8'($urandom_range(0, 3)), 1'b0);
                rand_sent++;
            end
            else
            begin
                // unused command codes, ignored by the block
                send(3'($urandom_range(5, 7)), 4'($urandom), 4'($urandom), 8'($urandom),
                     1'($urandom));
                rand_sent++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        clk           = 1'b0;
        cycles        = 0;
        rand_sent     = 0;
        no_idle       = 0;
        np_use        = NPROC;
        nr_use        = NRES;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        items.valid          = 1'b0;
        items.command        = '0;
        items.process_index  = '0;
        items.resource_index = '0;
        items.amount         = '0;
        items.request_last   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // clearing pass runs after reset; wait until the input opens
        do
            @(posedge clk);
        while (!items.ready);

        // directed, reset sizes: empty tables are safe
        send(CMD_CHECK, 4'd0, 4'd0, 8'd0, 1'b0);
        send(CMD_WRITE_ALLOC, 4'd15, 4'd15, 8'd255, 1'b1);
        send(CMD_WRITE_CLAIM, 4'd0, 4'd0, 8'd255, 1'b0);
        // need of 255 against nothing available: unsafe
        send(CMD_CHECK, 4'd15, 4'd15, 8'd255, 1'b1);
        send(CMD_WRITE_AVAIL, 4'd7, 4'd0, 8'd255, 1'b0);
        send(CMD_CHECK, 4'd0, 4'd0, 8'd0, 1'b0);
        send(3'd5, 4'd15, 4'd15, 8'd255, 1'b1);
        send(3'd6, 4'd0, 4'd0, 8'd0, 1'b0);
        send(3'd7, 4'd9, 4'd6, 8'd170, 1'b1);

        // small sizes for the request cases
        write_cfg(5'd2, 5'd2);
        send(CMD_WRITE_CLAIM, 4'd1, 4'd1, 8'd10, 1'b0);
        // grant: row 0 takes all 255 of resource 0
        send(CMD_REQUEST, 4'd0, 4'd1, 8'd0, 1'b0);
        send(CMD_REQUEST, 4'd0, 4'd0, 8'd255, 1'b1);
        // over need: row 0 has nothing left to claim
        send(CMD_REQUEST, 4'd0, 4'd0, 8'd1, 1'b1);
        // over available: row 1 may take 10 of resource 1, none available
        send(CMD_REQUEST, 4'd1, 4'd0, 8'd0, 1'b0);
        send(CMD_REQUEST, 4'd1, 4'd1, 8'd5, 1'b1);
        // over both: need wins
        send(CMD_REQUEST, 4'd1, 4'd1, 8'd200, 1'b1);

        // out-of-range register values act as the nearest legal size
        write_cfg(5'd0, 5'd0);
        random_phase(30);
        write_cfg(5'd31, 5'd17);
        random_phase(30);
        write_cfg(5'd1, 5'd16);
        random_phase(30);

        // hold off until the block has answered everything
        drain();
        write_cfg(5'd4, 5'd3);
        random_phase(40);
        write_cfg(5'd3, 5'd1);
        random_phase(30);
        write_cfg(5'(4'($urandom_range(1, 5))), 5'(4'($urandom_range(1, 4))));
        random_phase(40);

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
